// ===== sv/adcd_pkg.sv =====
`default_nettype none

package adcd_pkg;

    // Datagram layout (byte offsets)
    localparam logic [10:0] HEADER_BYTES  = 11'd18;
    localparam logic [10:0] MAX_FRAME     = 11'd530;
    localparam logic [10:0] POS_MAX       = 11'd2047;
    localparam logic [10:0] POS_OPC_LO    = 11'd8;
    localparam logic [10:0] POS_OPC_HI    = 11'd9;
    localparam logic [10:0] POS_LEN_HI    = 11'd16;
    localparam logic [10:0] POS_LEN_LO    = 11'd17;

    localparam logic [15:0] ARTDMX_OPCODE = 16'h5000;
    localparam logic [15:0] DMX_LEN_MIN   = 16'd2;

    localparam int CHANNEL_W = 9;
    localparam int LEVEL_W   = 8;

    // Store update request from the header parser
    typedef struct packed {
        logic                 hit;
        logic [CHANNEL_W-1:0] idx;
        logic [LEVEL_W-1:0]   level;
    } adcd_cand_t;

endpackage

`default_nettype wire

// ===== sv/adcd_ram.sv =====
`default_nettype none

// Simple dual-port RAM, registered read (read-first on same-address write).
module adcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  wire logic                                    clk,
    input  wire logic                                    wr_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                        wr_data,
    input  wire logic                                    rd_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/adcd_parse.sv =====
`default_nettype none

// Header tracker: byte position, opcode, DMX length, frame accept flag.
module adcd_parse #(
    parameter int CHANNELS = 512
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               accept,
    input  wire logic [7:0]         data_byte,
    input  wire logic               first_byte,
    input  wire logic [10:0]        frame_length,
    output adcd_pkg::adcd_cand_t    cand
);

    logic [10:0] pos_reg,  pos_next;
    logic [7:0]  opl_reg,  opl_next;
    logic [15:0] dlen_reg, dlen_next;
    logic        acc_reg,  acc_next;

    logic [10:0] pos;
    logic [7:0]  opl_cur;
    logic [15:0] dlen_cur;
    logic        acc_cur;
    logic [10:0] idx_full;
    logic [10:0] flen_lim;
    logic        in_data;
    logic [15:0] dlen_low;

    always_comb
    begin
        pos      = first_byte ? 11'd0 : pos_reg;
        opl_cur  = first_byte ? 8'd0  : opl_reg;
        dlen_cur = first_byte ? 16'd0 : dlen_reg;
        acc_cur  = first_byte ? 1'b0  : acc_reg;

        idx_full = pos - adcd_pkg::HEADER_BYTES;
        flen_lim = frame_length - adcd_pkg::HEADER_BYTES;
        dlen_low = {dlen_cur[15:8], data_byte};

        opl_next  = opl_cur;
        dlen_next = dlen_cur;
        acc_next  = acc_cur;
        in_data   = 1'b0;

        case (pos)
            adcd_pkg::POS_OPC_LO: opl_next = data_byte;
            adcd_pkg::POS_OPC_HI: acc_next = ({data_byte, opl_cur} == adcd_pkg::ARTDMX_OPCODE);
            adcd_pkg::POS_LEN_HI: dlen_next = {data_byte, 8'd0};
            adcd_pkg::POS_LEN_LO:
            begin
                dlen_next = dlen_low;
                if (dlen_low < adcd_pkg::DMX_LEN_MIN)
                begin
                    acc_next = 1'b0;
                end
            end
            default:
            begin
                in_data = (pos >= adcd_pkg::HEADER_BYTES) && acc_cur
                       && (frame_length <= adcd_pkg::MAX_FRAME)
                       && (frame_length > adcd_pkg::HEADER_BYTES);
            end
        endcase

        pos_next = (pos < adcd_pkg::POS_MAX) ? pos + 11'd1 : adcd_pkg::POS_MAX;

        cand.hit   = in_data && (idx_full < flen_lim)
                  && ({5'd0, idx_full} < dlen_cur)
                  && (idx_full < 11'(CHANNELS));
        cand.idx   = idx_full[adcd_pkg::CHANNEL_W-1:0];
        cand.level = data_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            opl_reg  <= '0;
            dlen_reg <= '0;
            acc_reg  <= 1'b0;
        end
        else if (accept)
        begin
            pos_reg  <= pos_next;
            opl_reg  <= opl_next;
            dlen_reg <= dlen_next;
            acc_reg  <= acc_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/adcd_update.sv =====
`default_nettype none

// Read-compare-write of the channel store, output register, clear sweep.
module adcd_update #(
    parameter int CHANNELS = 512
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  accept,
    input  wire adcd_pkg::adcd_cand_t  cand,
    output logic                       in_ready,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [adcd_pkg::CHANNEL_W-1:0] out_channel,
    output logic [adcd_pkg::LEVEL_W-1:0]   out_level
);

    localparam int ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic                           clr_active_reg, clr_active_next;
    logic [ADDR_W-1:0]              clr_addr_reg,   clr_addr_next;
    logic                           s1_valid_reg,   s1_valid_next;
    logic [adcd_pkg::CHANNEL_W-1:0] s1_idx_reg;
    logic [adcd_pkg::LEVEL_W-1:0]   s1_level_reg;
    logic                           fwd_hit_reg;
    logic [adcd_pkg::LEVEL_W-1:0]   fwd_level_reg;
    logic                           out_valid_reg,  out_valid_next;
    logic [adcd_pkg::CHANNEL_W-1:0] out_channel_reg;
    logic [adcd_pkg::LEVEL_W-1:0]   out_level_reg;

    logic [adcd_pkg::LEVEL_W-1:0]   rd_data;
    logic [adcd_pkg::LEVEL_W-1:0]   stored;
    logic                           change;
    logic                           s1_fire;
    logic                           wr_en;
    logic [ADDR_W-1:0]              wr_addr;
    logic [adcd_pkg::LEVEL_W-1:0]   wr_data;
    logic                           rd_en;

    always_comb
    begin
        stored   = fwd_hit_reg ? fwd_level_reg : rd_data;
        change   = s1_valid_reg && (stored != s1_level_reg);
        s1_fire  = s1_valid_reg && (!change || !out_valid_reg || out_ready);
        in_ready = !clr_active_reg && (!s1_valid_reg || s1_fire);
        rd_en    = accept && cand.hit;

        if (clr_active_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_addr_reg;
            wr_data = '0;
        end
        else
        begin
            wr_en   = s1_fire && change;
            wr_addr = s1_idx_reg[ADDR_W-1:0];
            wr_data = s1_level_reg;
        end

        clr_active_next = clr_active_reg;
        clr_addr_next   = clr_addr_reg;
        if (clr_active_reg)
        begin
            if (clr_addr_reg == ADDR_W'(CHANNELS - 1))
            begin
                clr_active_next = 1'b0;
            end
            else
            begin
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
            end
        end

        if (accept)
        begin
            s1_valid_next = cand.hit;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end

        if (s1_fire && change)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    adcd_ram #(
        .WIDTH (adcd_pkg::LEVEL_W),
        .DEPTH (CHANNELS)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (cand.idx[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
            s1_valid_reg   <= s1_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload; write-back in flight to the same entry is forwarded
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_idx_reg    <= cand.idx;
            s1_level_reg  <= cand.level;
            fwd_hit_reg   <= s1_fire && change && (s1_idx_reg == cand.idx);
            fwd_level_reg <= s1_level_reg;
        end
        if (s1_fire && change)
        begin
            out_channel_reg <= s1_idx_reg;
            out_level_reg   <= s1_level_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_channel = out_channel_reg;
    assign out_level   = out_level_reg;

endmodule

`default_nettype wire

// ===== sv/artnet_dmx_change_detector.sv =====
// An input transfer reaches the output through the store read into stage 1, then
// compare/write-back into the output register. Throughput: one byte per cycle
// while s_tready is high; the store does one read and one write a cycle. Apart
// from the clear sweep, s_tready drops only while a changed channel waits behind
// a stalled output. Reset: rst_n async active low clears control state, then a
// clear sweep zeroes every store entry (CHANNELS, 512 by default), s_tready low.
`default_nettype none

module artnet_dmx_change_detector #(
    parameter int CHANNELS = 512
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Input: datagram bytes
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,  // [7:0] data_byte, [18:8] frame_length, [23:19] zero
    input  wire logic        s_tuser,  // [0] first_byte
    // Output: changed channels
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [23:0] m_tdata   // [8:0] channel, [16:9] level, [23:17] zero
);

    logic                           accept;
    adcd_pkg::adcd_cand_t           cand;
    logic [adcd_pkg::CHANNEL_W-1:0] channel;
    logic [adcd_pkg::LEVEL_W-1:0]   level;

    // Every transfer advances the header tracker; only in-range data bytes
    // of an accepted frame go to the store.
    assign accept = s_tvalid && s_tready;

    adcd_parse #(
        .CHANNELS (CHANNELS)
    ) u_parse (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .data_byte    (s_tdata[7:0]),
        .first_byte   (s_tuser),
        .frame_length (s_tdata[18:8]),
        .cand         (cand)
    );

    // Stage 1 holds one store lookup; output register decouples m_tready,
    // so a new byte is taken while a result waits unless stage 1 also holds a change.
    adcd_update #(
        .CHANNELS (CHANNELS)
    ) u_update (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .cand        (cand),
        .in_ready    (s_tready),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_channel (channel),
        .out_level   (level)
    );

    assign m_tdata = {7'd0, level, channel};

endmodule

`default_nettype wire

// ===== sv/adcd_chk.sv =====
`default_nettype none

module adcd_chk (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [23:0] s_tdata,
    input wire logic        s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata
);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("m_tdata changed while stalled");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[23:17] == 7'd0)
        else $error("m_tdata padding not zero");

    // A result that appears on an idle output comes from an input transfer
    // registered into stage 1 and then into the output register
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !$past(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result without an input transfer two cycles earlier");

endmodule

bind artnet_dmx_change_detector adcd_chk u_adcd_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
